/* src/ctgr_pkg.sv */
// shared types, constants and the divider step for the gamma ramp core
package ctgr_pkg;

	localparam int IDX_W      = 16;
	localparam int LVL_W      = 16;
	localparam int GAIN_W     = 17;
	localparam int KELVIN_W   = 13;
	localparam int ENTRIES_W  = 17;
	localparam int CFG_W      = 17;
	localparam int DIV_STAGES = 16;

	localparam logic [GAIN_W-1:0]    GAIN_ONE         = 17'd65536;
	localparam logic [ENTRIES_W-1:0] MAX_RAMP_ENTRIES = 17'd65536;
	localparam logic [ENTRIES_W-1:0] ENTRIES_RESET    = 17'd256;
	localparam logic [ENTRIES_W-1:0] ENTRIES_MIN      = 17'd2;

	localparam logic [KELVIN_W-1:0] KELVIN_LOW      = 13'd2500;
	localparam logic [KELVIN_W-1:0] KELVIN_HIGH     = 13'd6500;
	localparam logic [KELVIN_W-1:0] KELVIN_BLUE_OFS = 13'd1000;
	localparam logic [KELVIN_W-1:0] LOG_BASE_N      = 13'd100;

	// fit coefficients, Q32
	localparam logic [30:0] GREEN_K1 = 31'd1161290208;
	localparam logic [32:0] GREEN_K0 = 33'd2713738337;
	localparam logic [30:0] BLUE_K1  = 31'd1617150769;
	localparam logic [32:0] BLUE_K0  = 33'd5137872191;

	// register indexes
	localparam logic [1:0] REG_KELVIN  = 2'd0;
	localparam logic [1:0] REG_NIGHT   = 2'd1;
	localparam logic [1:0] REG_ENTRIES = 2'd2;

	typedef enum logic [2:0] {
		GS_IDLE,
		GS_NORM,
		GS_SQR,
		GS_MUL,
		GS_SUB
	} gain_state_t;

	// partial remainder and dividend bits / quotient bits sharing one word
	typedef struct packed {
		logic [15:0] rem;
		logic [15:0] low;
	} div_word_t;

	typedef struct packed {
		logic        oor;
		logic [15:0] den;
		div_word_t   red;
		div_word_t   grn;
		div_word_t   blu;
	} div_pipe_t;

	function automatic div_word_t div_step(div_word_t w, logic [15:0] den);
		logic [16:0] t;
		logic [16:0] d;
		logic        qb;
		div_word_t   o;
		t  = {w.rem, w.low[15]};
		d  = t - {1'b0, den};
		qb = (t >= {1'b0, den});
		o.rem = qb ? d[15:0] : t[15:0];
		o.low = {w.low[14:0], qb};
		return o;
	endfunction

endpackage

/* src/ctgr_div_stage.sv */
// one pipelined restoring-division step for the three channels
module ctgr_div_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  ctgr_pkg::div_pipe_t in_data,
	output logic                out_valid,
	output ctgr_pkg::div_pipe_t out_data
);
	import ctgr_pkg::*;

	logic      valid_q;
	div_pipe_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q.oor <= in_data.oor;
		data_q.den <= in_data.den;
		data_q.red <= div_step(in_data.red, in_data.den);
		data_q.grn <= div_step(in_data.grn, in_data.den);
		data_q.blu <= div_step(in_data.blu, in_data.den);
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
endmodule

/* src/ctgr_gain_unit.sv */
// sequential log2 fit that turns a kelvin write into green and blue gains
module ctgr_gain_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              kick,
	input  logic [ctgr_pkg::KELVIN_W-1:0]     kelvin,
	output logic                              busy,
	output logic [ctgr_pkg::GAIN_W-1:0]       green_gain,
	output logic [ctgr_pkg::GAIN_W-1:0]       blue_gain
);
	import ctgr_pkg::*;

	gain_state_t         state_q, state_d;
	logic [KELVIN_W-1:0] kelvin_q;
	logic [1:0]          sel_q;
	logic [4:0]          cnt_q;
	logic [31:0]         m_q;
	logic [3:0]          e_q;
	logic [31:0]         frac_q;
	logic [35:0]         lh_q, lg_q, lb_q;
	logic                fsel_q;
	logic [58:0]         t_q;
	logic                pos_q;
	logic [GAIN_W-1:0]   green_q, blue_q;

	logic                kelvin_ok;
	logic [KELVIN_W-1:0] n_sel;
	logic [3:0]          e_n;
	logic [31:0]         m_norm;
	logic [63:0]         sq;
	logic [31:0]         m2;
	logic                big;
	logic [31:0]         frac_next;
	logic [35:0]         ln;
	logic [35:0]         diff;
	logic [30:0]         k1;
	logic [32:0]         k0;
	logic [58:0]         t_n;
	logic [58:0]         k0s;
	logic [58:0]         g_full;
	logic [18:0]         gq;
	logic [GAIN_W-1:0]   gain_n;

	assign kelvin_ok = (kelvin >= KELVIN_LOW) && (kelvin < KELVIN_HIGH);

	always_comb begin
		case (sel_q)
			2'd0:    n_sel = LOG_BASE_N;
			2'd1:    n_sel = kelvin_q;
			default: n_sel = kelvin_q - KELVIN_BLUE_OFS;
		endcase
	end

	// leading one position
	always_comb begin
		e_n = 4'd0;
		for (int i = 1; i < KELVIN_W; i++) begin
			if (n_sel[i]) e_n = 4'(i);
		end
	end

	assign m_norm    = {19'd0, n_sel} << (5'd30 - {1'b0, e_n});
	assign sq        = {32'd0, m_q} * {32'd0, m_q};
	assign m2        = sq[61:30];
	assign big       = m2[31];
	assign frac_next = {frac_q[30:0], big};

	assign ln   = fsel_q ? lb_q : lg_q;
	assign diff = ln - lh_q;
	assign k1   = fsel_q ? BLUE_K1 : GREEN_K1;
	assign k0   = fsel_q ? BLUE_K0 : GREEN_K0;
	assign t_n  = {28'd0, k1} * {31'd0, diff[35:8]};
	assign k0s  = {2'd0, k0, 24'd0};

	assign g_full = t_q - k0s;
	assign gq     = g_full[58:40];
	always_comb begin
		if (!pos_q || (t_q <= k0s)) begin
			gain_n = '0;
		end else if (gq > {2'd0, GAIN_ONE}) begin
			gain_n = GAIN_ONE;
		end else begin
			gain_n = gq[GAIN_W-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			GS_IDLE: state_d = GS_IDLE;
			GS_NORM: state_d = GS_SQR;
			GS_SQR: begin
				if (cnt_q == 5'd0) state_d = (sel_q == 2'd2) ? GS_MUL : GS_NORM;
			end
			GS_MUL: state_d = GS_SUB;
			GS_SUB: state_d = fsel_q ? GS_IDLE : GS_MUL;
			default: state_d = GS_IDLE;
		endcase
		// a kelvin write restarts the fit from any state; an out-of-range kelvin returns to idle
		if (kick) state_d = kelvin_ok ? GS_NORM : GS_IDLE;
	end

	always_comb begin
		case (state_q)
			GS_IDLE: busy = 1'b0;
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= GS_IDLE;
			sel_q   <= 2'd0;
			fsel_q  <= 1'b0;
			cnt_q   <= 5'd0;
			green_q <= GAIN_ONE;
			blue_q  <= GAIN_ONE;
		end else begin
			state_q <= state_d;
			if (kick) begin
				sel_q  <= 2'd0;
				fsel_q <= 1'b0;
				if (!kelvin_ok) begin
					green_q <= GAIN_ONE;
					blue_q  <= GAIN_ONE;
				end
			end else begin
				case (state_q)
					GS_NORM: cnt_q <= 5'd31;
					GS_SQR: begin
						cnt_q <= cnt_q - 5'd1;
						if (cnt_q == 5'd0) sel_q <= sel_q + 2'd1;
					end
					GS_SUB: begin
						if (fsel_q) blue_q <= gain_n;
						else green_q <= gain_n;
						fsel_q <= ~fsel_q;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (kick) kelvin_q <= kelvin;
		if (state_q == GS_NORM) begin
			m_q    <= m_norm;
			e_q    <= e_n;
			frac_q <= '0;
		end
		if (state_q == GS_SQR) begin
			m_q    <= big ? (m2 >> 1) : m2;
			frac_q <= frac_next;
			if (cnt_q == 5'd0) begin
				case (sel_q)
					2'd0:    lh_q <= {e_q, frac_next};
					2'd1:    lg_q <= {e_q, frac_next};
					default: lb_q <= {e_q, frac_next};
				endcase
			end
		end
		if (state_q == GS_MUL) begin
			t_q   <= t_n;
			pos_q <= ln > lh_q;
		end
	end

	assign green_gain = green_q;
	assign blue_gain  = blue_q;
endmodule

/* src/color_temperature_gamma_ramp_core.sv */
// gamma ramp core: config registers, gain unit and the ramp entry pipeline
//
// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------
// command   | start / busy         | ramp_index
// result    | done (one cycle)     | red_level green_level blue_level out_of_range
// config    | cfg_we               | cfg_index cfg_data
//
// one ramp entry enters per cycle while busy is low; each result passes through
// two setup stages (range check, gain multiply) and 16 one-bit divider stages.
// an in-range kelvin write keeps busy high while the log2 fit runs
// (three 32-step squaring loops on one multiplier, then two fit steps per gain).
// reset restores night mode off, 256 entries and unity gains.
// results cannot be held off; the pipeline never stalls.
module color_temperature_gamma_ramp_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [ctgr_pkg::IDX_W-1:0]       ramp_index,
	output logic                             done,
	output logic [ctgr_pkg::LVL_W-1:0]       red_level,
	output logic [ctgr_pkg::LVL_W-1:0]       green_level,
	output logic [ctgr_pkg::LVL_W-1:0]       blue_level,
	output logic                             out_of_range,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [ctgr_pkg::CFG_W-1:0]       cfg_data
);
	import ctgr_pkg::*;

	logic                 night_q;
	logic [ENTRIES_W-1:0] entries_q;
	logic                 kick;
	logic [GAIN_W-1:0]    green_gain, blue_gain;

	logic                 accept;
	logic                 oor_n;
	logic [ENTRIES_W-1:0] den_full;
	logic [31:0]          num_n;

	logic                 valid_s1, oor_s1;
	logic [31:0]          num_s1;
	logic [15:0]          den_s1;
	logic [GAIN_W-1:0]    gg_s1, bg_s1;
	logic [48:0]          prod_g, prod_b;

	logic                 valid_s2;
	div_pipe_t            pipe_s2;

	logic                 dv [DIV_STAGES+1];
	div_pipe_t            dp [DIV_STAGES+1];

	assign kick = cfg_we && (cfg_index == REG_KELVIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			night_q   <= 1'b0;
			entries_q <= ENTRIES_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_NIGHT) night_q <= cfg_data[0];
			if (cfg_index == REG_ENTRIES) entries_q <= cfg_data;
		end
	end

	ctgr_gain_unit u_gain (
		.clk        (clk),
		.arst_n     (arst_n),
		.kick       (kick),
		.kelvin     (cfg_data[KELVIN_W-1:0]),
		.busy       (busy),
		.green_gain (green_gain),
		.blue_gain  (blue_gain)
	);

	assign accept   = start && !busy;
	assign oor_n    = (entries_q < ENTRIES_MIN) || (entries_q > MAX_RAMP_ENTRIES)
		|| ({1'b0, ramp_index} >= entries_q);
	assign den_full = entries_q - 17'd1;
	// 65535 * i
	assign num_n    = {ramp_index, 16'd0} - {16'd0, ramp_index};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		oor_s1 <= oor_n;
		num_s1 <= oor_n ? 32'd0 : num_n;
		den_s1 <= oor_n ? 16'd1 : den_full[15:0];
		gg_s1  <= night_q ? green_gain : GAIN_ONE;
		bg_s1  <= night_q ? blue_gain : GAIN_ONE;
	end

	assign prod_g = {17'd0, num_s1} * {32'd0, gg_s1};
	assign prod_b = {17'd0, num_s1} * {32'd0, bg_s1};

	// scaled numerators never exceed the red one, so every quotient fits 16 bits
	always_ff @(posedge clk) begin
		pipe_s2.oor <= oor_s1;
		pipe_s2.den <= den_s1;
		pipe_s2.red <= num_s1;
		pipe_s2.grn <= prod_g[47:16];
		pipe_s2.blu <= prod_b[47:16];
	end

	assign dv[0] = valid_s2;
	assign dp[0] = pipe_s2;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		ctgr_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv[g]),
			.in_data   (dp[g]),
			.out_valid (dv[g+1]),
			.out_data  (dp[g+1])
		);
	end

	assign done         = dv[DIV_STAGES];
	assign out_of_range = dp[DIV_STAGES].oor;
	assign red_level    = dp[DIV_STAGES].oor ? '0 : dp[DIV_STAGES].red.low;
	assign green_level  = dp[DIV_STAGES].oor ? '0 : dp[DIV_STAGES].grn.low;
	assign blue_level   = dp[DIV_STAGES].oor ? '0 : dp[DIV_STAGES].blu.low;

`ifndef SYNTHESIS
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_of_range |-> red_level == '0 && green_level == '0 && blue_level == '0)
		else $error("out of range transaction with nonzero levels");

	a_gain_le_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> green_level <= red_level && blue_level <= red_level)
		else $error("scaled level above red level");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(cfg_we) && $past(cfg_index) == REG_KELVIN)
		else $error("gain unit started without kelvin write");
`endif
endmodule
